// File: design/crc16_frame_checker_parser_macros.svh
// Assertion macros shared by the packet checker.
`ifndef CRC16_FRAME_CHECKER_PARSER_MACROS_SVH
`define CRC16_FRAME_CHECKER_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFCP_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFCP_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cfcp_pkg.sv
// Shared types and constants of the CRC-16 packet checker.
package cfcp_pkg;

  localparam int unsigned MIN_PACKET_LEN = 10;  // header plus trailing CRC
  localparam int unsigned CMD_ID_LIMIT   = 64;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam int unsigned CFG_ADDR_W     = 6;
  localparam int unsigned CFG_DATA_W     = 64;

  typedef enum logic [2:0] {
    REG_PROTOCOL_VERSION,
    REG_COMMAND_TYPE_CODE,
    REG_RESPONSE_TYPE_CODE,
    REG_TELEMETRY_TYPE_CODE,
    REG_MAX_PAYLOAD_LENGTH,
    REG_MAX_PACKET_LENGTH,
    REG_COMMAND_VALID_MASK,
    REG_PARSE_COMMAND_MODE
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SIZE        = 4'd1,
    ST_VERSION     = 4'd2,
    ST_TYPE        = 4'd3,
    ST_PAYLOAD_BIG = 4'd4,
    ST_LENGTH      = 4'd5,
    ST_CRC         = 4'd6,
    ST_NOT_COMMAND = 4'd7,
    ST_EMPTY       = 4'd8,
    ST_BAD_COMMAND = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0]  protocol_version;
    logic [7:0]  command_type_code;
    logic [7:0]  response_type_code;
    logic [7:0]  telemetry_type_code;
    logic [15:0] max_payload_length;
    logic [15:0] max_packet_length;
    logic [63:0] command_valid_mask;
    logic        parse_command_mode;
  } cfg_t;

  // Packet state as it stands once the current word is folded in.
  typedef struct packed {
    logic [15:0] pos;
    logic [7:0]  version;
    logic [7:0]  ptype;
    logic [15:0] node;
    logic [15:0] seq;
    logic [15:0] len;
    logic [7:0]  cmd;
    logic [15:0] crc;
    logic [15:0] rx_crc;
  } frame_view_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] command_payload_length;
  } verdict_t;

endpackage

// File: design/cfcp_ifs.sv
// Valid/ready channel interfaces for packet words and check results.
interface cfcp_packet_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cfcp_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  packet_type;
  logic [15:0] node_id;
  logic [15:0] sequence_number;
  logic [15:0] header_payload_length;
  logic [7:0]  command_id;
  logic [15:0] command_payload_length;

  modport source (output valid, status, packet_type, node_id, sequence_number,
                  header_payload_length, command_id, command_payload_length,
                  input ready);
  modport sink   (input valid, status, packet_type, node_id, sequence_number,
                  header_payload_length, command_id, command_payload_length,
                  output ready);
endinterface

// File: design/cfcp_cfg_regs.sv
// APB configuration register file of the packet checker.
module cfcp_cfg_regs import cfcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr;

  // Registers sit on 8-byte strides
  assign idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version    <= 8'd1;
      cfg.command_type_code   <= 8'd1;
      cfg.response_type_code  <= 8'd2;
      cfg.telemetry_type_code <= 8'd3;
      cfg.max_payload_length  <= 16'd256;
      cfg.max_packet_length   <= 16'd266;
      cfg.command_valid_mask  <= 64'd0;
      cfg.parse_command_mode  <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_PROTOCOL_VERSION:    cfg.protocol_version    <= pwdata[7:0];
        REG_COMMAND_TYPE_CODE:   cfg.command_type_code   <= pwdata[7:0];
        REG_RESPONSE_TYPE_CODE:  cfg.response_type_code  <= pwdata[7:0];
        REG_TELEMETRY_TYPE_CODE: cfg.telemetry_type_code <= pwdata[7:0];
        REG_MAX_PAYLOAD_LENGTH:  cfg.max_payload_length  <= pwdata[15:0];
        REG_MAX_PACKET_LENGTH:   cfg.max_packet_length   <= pwdata[15:0];
        REG_COMMAND_VALID_MASK:  cfg.command_valid_mask  <= pwdata[63:0];
        REG_PARSE_COMMAND_MODE:  cfg.parse_command_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_PROTOCOL_VERSION:    prdata[7:0]  = cfg.protocol_version;
      REG_COMMAND_TYPE_CODE:   prdata[7:0]  = cfg.command_type_code;
      REG_RESPONSE_TYPE_CODE:  prdata[7:0]  = cfg.response_type_code;
      REG_TELEMETRY_TYPE_CODE: prdata[7:0]  = cfg.telemetry_type_code;
      REG_MAX_PAYLOAD_LENGTH:  prdata[15:0] = cfg.max_payload_length;
      REG_MAX_PACKET_LENGTH:   prdata[15:0] = cfg.max_packet_length;
      REG_COMMAND_VALID_MASK:  prdata[63:0] = cfg.command_valid_mask;
      REG_PARSE_COMMAND_MODE:  prdata[0]    = cfg.parse_command_mode;
      default:                 prdata       = '0;
    endcase
  end

endmodule

// File: design/cfcp_frame_state.sv
// Per-packet state: header capture, CRC delay line, running CRC, word count.
module cfcp_frame_state import cfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output frame_view_t view
);

  logic [15:0] running_crc, running_crc_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  delay_bytes [2];
  logic [7:0]  header_version, header_version_next;
  logic [7:0]  header_type, header_type_next;
  logic [15:0] header_node, header_node_next;
  logic [15:0] header_sequence, header_sequence_next;
  logic [15:0] header_length, header_length_next;
  logic [7:0]  command_byte, command_byte_next;

  // Reflected CRC-16, one byte, unrolled over its eight bits
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_comb begin
    header_version_next  = header_version;
    header_type_next     = header_type;
    header_node_next     = header_node;
    header_sequence_next = header_sequence;
    header_length_next   = header_length;
    command_byte_next    = command_byte;
    case (byte_count)
      16'd0: header_version_next  = data_byte;
      16'd1: header_type_next     = data_byte;
      16'd2: header_node_next     = {data_byte, header_node[7:0]};
      16'd3: header_node_next     = {header_node[15:8], data_byte};
      16'd4: header_sequence_next = {data_byte, header_sequence[7:0]};
      16'd5: header_sequence_next = {header_sequence[15:8], data_byte};
      16'd6: header_length_next   = {data_byte, header_length[7:0]};
      16'd7: header_length_next   = {header_length[15:8], data_byte};
      16'd8: command_byte_next    = data_byte;
      default: ;
    endcase
    // The word two places back leaves the delay line into the CRC
    running_crc_next = (byte_count >= 16'd2) ? crc_feed(running_crc, delay_bytes[0])
                                             : running_crc;
    byte_count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
  end

  always_comb begin
    view.pos     = byte_count;
    view.version = header_version_next;
    view.ptype   = header_type_next;
    view.node    = header_node_next;
    view.seq     = header_sequence_next;
    view.len     = header_length_next;
    view.cmd     = command_byte_next;
    view.crc     = running_crc_next;
    view.rx_crc  = {delay_bytes[1], data_byte};
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      running_crc     <= CRC_INIT;
      byte_count      <= '0;
      delay_bytes[0]  <= '0;
      delay_bytes[1]  <= '0;
      header_version  <= '0;
      header_type     <= '0;
      header_node     <= '0;
      header_sequence <= '0;
      header_length   <= '0;
      command_byte    <= '0;
    end else if (step) begin
      running_crc     <= running_crc_next;
      byte_count      <= byte_count_next;
      delay_bytes[0]  <= delay_bytes[1];
      delay_bytes[1]  <= data_byte;
      header_version  <= header_version_next;
      header_type     <= header_type_next;
      header_node     <= header_node_next;
      header_sequence <= header_sequence_next;
      header_length   <= header_length_next;
      command_byte    <= command_byte_next;
    end
  end

endmodule

// File: design/cfcp_status_eval.sv
// Ordered packet checks: picks the first failing one.
module cfcp_status_eval import cfcp_pkg::*; (
  input  cfg_t        cfg,
  input  frame_view_t view,
  output verdict_t    verdict
);

  logic [16:0] total;
  logic [16:0] expected;
  logic        type_known;
  logic        cmd_ok;

  assign total      = {1'b0, view.pos} + 17'd1;
  assign expected   = 17'(MIN_PACKET_LEN) + {1'b0, view.len};
  assign type_known = (view.ptype == cfg.command_type_code) ||
                      (view.ptype == cfg.response_type_code) ||
                      (view.ptype == cfg.telemetry_type_code);
  assign cmd_ok     = (view.cmd < 8'(CMD_ID_LIMIT)) &&
                      cfg.command_valid_mask[view.cmd[5:0]];

  always_comb begin
    if (total < 17'(MIN_PACKET_LEN) || total > {1'b0, cfg.max_packet_length})
      verdict.status = ST_SIZE;
    else if (view.version != cfg.protocol_version)
      verdict.status = ST_VERSION;
    else if (!type_known)
      verdict.status = ST_TYPE;
    else if (view.len > cfg.max_payload_length)
      verdict.status = ST_PAYLOAD_BIG;
    else if (total != expected)
      verdict.status = ST_LENGTH;
    else if (view.rx_crc != view.crc)
      verdict.status = ST_CRC;
    else if (cfg.parse_command_mode && view.ptype != cfg.command_type_code)
      verdict.status = ST_NOT_COMMAND;
    else if (cfg.parse_command_mode && view.len == 16'd0)
      verdict.status = ST_EMPTY;
    else if (cfg.parse_command_mode && !cmd_ok)
      verdict.status = ST_BAD_COMMAND;
    else
      verdict.status = ST_OK;

    verdict.command_payload_length =
      (cfg.parse_command_mode && view.len != 16'd0) ? view.len - 16'd1 : 16'd0;
  end

endmodule

// File: design/crc16_frame_checker_parser.sv
// Packet checker: takes one word (byte) per cycle on the packet channel, save
// for a last word held by a pending result; checks the 8-byte big-endian
// header, the command byte and the trailing CRC-16 (reflected poly 0xA001,
// start 0xFFFF, sent MSB first, covering all but the last two words) and
// gives one result word per packet, on its last word. Throughput is one word
// per clock with no gaps between packets while no last word waits on a pending
// result. The last word passes the input register, then the result register
// loads once that word is folded in. The eight-bit unrolled CRC update and
// the ordered check chain sit between the two registers. A pending result that
// is not taken stalls only the last word of the next packet; every other word
// keeps flowing. Configuration is by APB, 64-bit data, register i at byte
// address 8*i; write it only while no packet is in flight.
`include "crc16_frame_checker_parser_macros.svh"

module crc16_frame_checker_parser import cfcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  cfcp_packet_if.sink           packet,
  cfcp_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  // Result register
  logic        out_valid;
  status_t     out_status;
  logic [7:0]  out_type;
  logic [15:0] out_node;
  logic [15:0] out_seq;
  logic [15:0] out_len;
  logic [7:0]  out_cmd;
  logic [15:0] out_cmd_len;

  logic        step;
  cfg_t        cfg;
  frame_view_t view;
  verdict_t    verdict;

  assign pready = 1'b1;

  // Fold the held word in unless it is a last word and the result slot is
  // occupied and not being taken; words without a result never wait.
  assign step         = in_valid && (!in_last || !out_valid || result.ready);
  assign packet.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (packet.ready) begin
      in_valid <= packet.valid;
    end
  end

  // Payload: capture with the handshake, no reset needed
  always_ff @(posedge clk) begin
    if (packet.valid && packet.ready) begin
      in_byte <= packet.data_byte;
      in_last <= packet.last_byte;
    end
  end

  cfcp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cfcp_frame_state u_frame_state (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .view      (view)
  );

  cfcp_status_eval u_status_eval (
    .cfg     (cfg),
    .view    (view),
    .verdict (verdict)
  );

  // Result valid: set by a last word, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_status  <= verdict.status;
      out_type    <= view.ptype;
      out_node    <= view.node;
      out_seq     <= view.seq;
      out_len     <= view.len;
      out_cmd     <= view.cmd;
      out_cmd_len <= verdict.command_payload_length;
    end
  end

  assign result.valid                  = out_valid;
  assign result.status                 = out_status;
  assign result.packet_type            = out_type;
  assign result.node_id                = out_node;
  assign result.sequence_number        = out_seq;
  assign result.header_payload_length  = out_len;
  assign result.command_id             = out_cmd;
  assign result.command_payload_length = out_cmd_len;

  // A last word blocked by an untaken result must still be held next cycle
  `CFCP_ASSERT_NEXT(a_last_word_held, clk, rst,
                    in_valid && in_last && out_valid && !result.ready,
                    in_valid && in_last, "blocked last word was lost")
  // Packet state returns to its start once a packet closes
  `CFCP_ASSERT_NEXT(a_count_cleared, clk, rst, step && in_last, view.pos == 16'd0,
                    "word count not cleared after last word")
  // Word count advances by one per non-final word until it saturates
  `CFCP_ASSERT_NEXT(a_count_advance, clk, rst,
                    step && !in_last && view.pos != COUNT_MAX,
                    view.pos == $past(view.pos) + 16'd1, "word count did not advance")

endmodule

// File: verif/crc16_frame_checker_parser_tb.sv
// Self-checking testbench for the CRC-16 packet checker, with its own frame predictor.
`timescale 1ns / 1ps

module crc16_frame_checker_parser_tb;
  import cfcp_pkg::*;

  // One result word as the checker reports it.
  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  ptype;
    logic [15:0] node;
    logic [15:0] seq;
    logic [15:0] hlen;
    logic [7:0]  cmd;
    logic [15:0] cpl;
  } verdict_word_t;

  // One directed packet. Rows with typed set carry their own expected verdict.
  typedef struct {
    int          phase;
    logic [7:0]  ver;
    logic [7:0]  ptype;
    logic [15:0] node;
    logic [15:0] seq;
    logic [15:0] hlen;
    int          plen;
    logic [7:0]  cmd;
    bit          good_crc;
    int          cut;
    bit          typed;
    status_t     st;
    logic [15:0] cpl;
  } probe_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  cfcp_packet_if pkt_ch ();
  cfcp_result_if res_ch ();

  crc16_frame_checker_parser DUT (
    .clk     (clk),
    .rst     (rst),
    .packet  (pkt_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and of the packet in flight.
  cfg_t        cfg;
  logic [15:0] fr_crc;
  logic [15:0] fr_count;
  logic [7:0]  fr_hold0;
  logic [7:0]  fr_hold1;
  logic [7:0]  fr_ver;
  logic [7:0]  fr_type;
  logic [15:0] fr_node;
  logic [15:0] fr_seq;
  logic [15:0] fr_len;
  logic [7:0]  fr_cmd;

  verdict_word_t pending_verdicts[$];
  verdict_word_t head_verdict;
  int            mismatch_count = 0;
  int            sink_stall_left = 0;
  bit            src_idle_en;
  bit            sink_idle_en;

  // Directed packets. Phase 0 runs on the reset settings (mask clear, so any
  // command is refused); phase 1 opens the mask and both length limits;
  // phase 2 drops command parsing. Short packets, the empty-payload case and
  // any row whose command byte lands on the CRC are left to the predictor.
  probe_row_t probe_rows [0:17] = '{
    '{0, 8'h01, 8'h01, 16'h0000, 16'h0000, 16'd4,     4,   8'd5,   1, 0, 1, ST_BAD_COMMAND, 16'd3},
    '{0, 8'h00, 8'h01, 16'hFFFF, 16'hFFFF, 16'd2,     2,   8'hFF,  1, 0, 1, ST_VERSION,     16'd1},
    '{0, 8'h01, 8'hFF, 16'h1234, 16'h5678, 16'd2,     2,   8'd7,   1, 0, 1, ST_TYPE,        16'd1},
    '{0, 8'h01, 8'h03, 16'h0001, 16'h0002, 16'hFFFF,  2,   8'd9,   1, 0, 1, ST_PAYLOAD_BIG, 16'hFFFE},
    '{0, 8'h01, 8'h02, 16'h00AA, 16'h0055, 16'd5,     4,   8'd3,   1, 0, 1, ST_LENGTH,      16'd4},
    '{0, 8'h01, 8'h01, 16'h8000, 16'h0001, 16'd3,     3,   8'd2,   0, 0, 1, ST_CRC,         16'd2},
    '{0, 8'h01, 8'h02, 16'h7FFF, 16'h8000, 16'd1,     1,   8'd1,   1, 0, 1, ST_NOT_COMMAND, 16'd0},
    '{0, 8'h01, 8'h01, 16'h0000, 16'h0000, 16'd0,     0,   8'd0,   1, 0, 0, ST_EMPTY,       16'd0},
    '{0, 8'h01, 8'h01, 16'h1111, 16'h2222, 16'd4,     4,   8'd1,   1, 1, 0, ST_SIZE,        16'd0},
    '{0, 8'h01, 8'h01, 16'h1111, 16'h2222, 16'd4,     4,   8'd1,   1, 9, 0, ST_SIZE,        16'd0},
    '{0, 8'h01, 8'h01, 16'h4321, 16'h8765, 16'd257,   257, 8'd5,   1, 0, 1, ST_SIZE,        16'd256},
    '{1, 8'h01, 8'h01, 16'hFFFF, 16'h0000, 16'd1,     1,   8'd63,  1, 0, 1, ST_OK,          16'd0},
    '{1, 8'h01, 8'h01, 16'h0000, 16'hFFFF, 16'd1,     1,   8'd64,  1, 0, 1, ST_BAD_COMMAND, 16'd0},
    '{1, 8'h01, 8'h01, 16'h5A5A, 16'hA5A5, 16'd20,    20,  8'd0,   1, 0, 1, ST_OK,          16'd19},
    '{1, 8'h01, 8'h01, 16'h0001, 16'h0001, 16'd2,     2,   8'hFF,  1, 0, 1, ST_BAD_COMMAND, 16'd1},
    '{2, 8'h01, 8'h03, 16'h0C0C, 16'h0D0D, 16'd2,     2,   8'hC8,  1, 0, 1, ST_OK,          16'd0},
    '{2, 8'h01, 8'h01, 16'h0000, 16'h0000, 16'd0,     0,   8'd0,   1, 0, 0, ST_OK,          16'd0},
    '{2, 8'h01, 8'h02, 16'h0003, 16'h0004, 16'd5,     5,   8'd6,   0, 0, 1, ST_CRC,         16'd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #(2_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Reflected CRC-16, one byte, bit by bit.
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic frame_clear();
    fr_crc   = CRC_INIT;
    fr_count = '0;
    fr_hold0 = '0;
    fr_hold1 = '0;
    fr_ver   = '0;
    fr_type  = '0;
    fr_node  = '0;
    fr_seq   = '0;
    fr_len   = '0;
    fr_cmd   = '0;
  endtask

  // Fold one accepted word into the predicted packet; on the last word give
  // the verdict and return the packet state to its idle values.
  task automatic fold_word(input logic [7:0] b, input logic l, output bit done,
                           output verdict_word_t v);
    logic [15:0] pos;
    logic [15:0] rx;
    int unsigned total;
    status_t     st;
    v = '0;
    pos = fr_count;
    case (pos)
      16'd0: fr_ver = b;
      16'd1: fr_type = b;
      16'd2: fr_node[15:8] = b;
      16'd3: fr_node[7:0] = b;
      16'd4: fr_seq[15:8] = b;
      16'd5: fr_seq[7:0] = b;
      16'd6: fr_len[15:8] = b;
      16'd7: fr_len[7:0] = b;
      16'd8: fr_cmd = b;
      default: ;
    endcase
    // The word two places back leaves the delay line and enters the CRC.
    if (pos >= 16'd2)
      fr_crc = crc16_step(fr_crc, fr_hold0);
    rx = {fr_hold1, b};
    fr_hold0 = fr_hold1;
    fr_hold1 = b;
    if (fr_count != COUNT_MAX)
      fr_count = fr_count + 16'd1;
    done = l;
    if (!l)
      return;

    // First failing check wins; the length sum is taken in 32 bits.
    total = int'(pos) + 1;
    if (total < MIN_PACKET_LEN || total > cfg.max_packet_length)
      st = ST_SIZE;
    else if (fr_ver != cfg.protocol_version)
      st = ST_VERSION;
    else if (fr_type != cfg.command_type_code && fr_type != cfg.response_type_code &&
             fr_type != cfg.telemetry_type_code)
      st = ST_TYPE;
    else if (fr_len > cfg.max_payload_length)
      st = ST_PAYLOAD_BIG;
    else if (total != MIN_PACKET_LEN + int'(fr_len))
      st = ST_LENGTH;
    else if (rx != fr_crc)
      st = ST_CRC;
    else if (cfg.parse_command_mode) begin
      if (fr_type != cfg.command_type_code)
        st = ST_NOT_COMMAND;
      else if (fr_len == 16'd0)
        st = ST_EMPTY;
      else if (fr_cmd >= CMD_ID_LIMIT || !cfg.command_valid_mask[fr_cmd[5:0]])
        st = ST_BAD_COMMAND;
      else
        st = ST_OK;
    end else begin
      st = ST_OK;
    end

    v.status = st;
    v.ptype  = fr_type;
    v.node   = fr_node;
    v.seq    = fr_seq;
    v.hlen   = fr_len;
    v.cmd    = fr_cmd;
    v.cpl    = (cfg.parse_command_mode && fr_len != 16'd0) ? fr_len - 16'd1 : 16'd0;
    frame_clear();
  endtask

  function automatic logic [63:0] cfg_field(reg_idx_t idx);
    case (idx)
      REG_PROTOCOL_VERSION:    return 64'(cfg.protocol_version);
      REG_COMMAND_TYPE_CODE:   return 64'(cfg.command_type_code);
      REG_RESPONSE_TYPE_CODE:  return 64'(cfg.response_type_code);
      REG_TELEMETRY_TYPE_CODE: return 64'(cfg.telemetry_type_code);
      REG_MAX_PAYLOAD_LENGTH:  return 64'(cfg.max_payload_length);
      REG_MAX_PACKET_LENGTH:   return 64'(cfg.max_packet_length);
      REG_COMMAND_VALID_MASK:  return cfg.command_valid_mask;
      default:                 return 64'(cfg.parse_command_mode);
    endcase
  endfunction

  // One APB transfer: setup, access, then idle so that the next
  // transfer never lowers and raises psel in the same step.
  task automatic apb_xfer(input bit wr, input reg_idx_t idx, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, mirror it in the predictor and read it back.
  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    logic [63:0] rd;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_PROTOCOL_VERSION:    cfg.protocol_version = val[7:0];
      REG_COMMAND_TYPE_CODE:   cfg.command_type_code = val[7:0];
      REG_RESPONSE_TYPE_CODE:  cfg.response_type_code = val[7:0];
      REG_TELEMETRY_TYPE_CODE: cfg.telemetry_type_code = val[7:0];
      REG_MAX_PAYLOAD_LENGTH:  cfg.max_payload_length = val[15:0];
      REG_MAX_PACKET_LENGTH:   cfg.max_packet_length = val[15:0];
      REG_COMMAND_VALID_MASK:  cfg.command_valid_mask = val;
      default:                 cfg.parse_command_mode = val[0];
    endcase
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== cfg_field(idx))
      report_mismatch($sformatf("register %s reads %0h want %0h", idx.name(), rd,
                                cfg_field(idx)));
  endtask

  // Offer one packet word and hold it until taken; then maybe idle a burst.
  task automatic send_word(input logic [7:0] b, input logic l, input bit typed,
                           input verdict_word_t typed_v);
    bit            done;
    verdict_word_t v;
    pkt_ch.valid     <= 1'b1;
    pkt_ch.data_byte <= b;
    pkt_ch.last_byte <= l;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
    fold_word(b, l, done, v);
    if (done)
      pending_verdicts.push_back(typed ? typed_v : v);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      pkt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] q[$], input bit typed,
                            input verdict_word_t typed_v);
    foreach (q[i])
      send_word(q[i], i == q.size() - 1, typed, typed_v);
  endtask

  // Header, payload (command id first) and the CRC trailer, MSB first.
  function automatic void build_frame(output logic [7:0] q[$], input logic [7:0] ver,
                                      input logic [7:0] ptype, input logic [15:0] node,
                                      input logic [15:0] seq, input logic [15:0] hlen,
                                      input int plen, input logic [7:0] cmd,
                                      input bit good_crc);
    logic [15:0] c;
    q = {};
    q.push_back(ver);
    q.push_back(ptype);
    q.push_back(node[15:8]);
    q.push_back(node[7:0]);
    q.push_back(seq[15:8]);
    q.push_back(seq[7:0]);
    q.push_back(hlen[15:8]);
    q.push_back(hlen[7:0]);
    for (int i = 0; i < plen; i++)
      q.push_back(i == 0 ? cmd : 8'($urandom));
    c = CRC_INIT;
    foreach (q[i])
      c = crc16_step(c, q[i]);
    if (!good_crc)
      c = c ^ 16'($urandom_range(1, 16'hFFFF));
    q.push_back(c[15:8]);
    q.push_back(c[7:0]);
  endfunction

  // Mostly well-formed packets built on the current settings; a share carry
  // one broken field, and a few are plain noise.
  task automatic send_random_frame(output int n_sent);
    logic [7:0]    q[$];
    logic [7:0]    ver;
    logic [7:0]    ptype;
    logic [15:0]   hlen;
    logic [7:0]    cmd;
    int            plen;
    int            pick;
    bit            good;
    verdict_word_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 24)) q.push_back(8'($urandom));
    end else begin
      ver = cfg.protocol_version;
      case ($urandom_range(0, 3))
        0: ptype = cfg.response_type_code;
        1: ptype = cfg.telemetry_type_code;
        default: ptype = cfg.command_type_code;
      endcase
      hlen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(11, 60))
                                         : 16'($urandom_range(0, 10));
      plen = int'(hlen);
      cmd = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 63)) : 8'($urandom);
      good = 1'b1;
      if (pick >= 72) begin
        case ($urandom_range(0, 4))
          0: ver = ver ^ 8'($urandom_range(1, 255));
          1: ptype = 8'($urandom);
          2: plen = (hlen == 0 || $urandom_range(0, 1)) ? int'(hlen) + 1 : int'(hlen) - 1;
          3: good = 1'b0;
          default: hlen = 16'($urandom);
        endcase
      end
      build_frame(q, ver, ptype, 16'($urandom), 16'($urandom), hlen, plen, cmd, good);
    end
    send_frame(q, 1'b0, none);
    n_sent = q.size();
  endtask

  // Drop valid, wait for every outstanding verdict, then let the two-stage
  // pipeline settle before touching the registers.
  task automatic drain_results();
    pkt_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result sink: stall in random bursts while enabled.
  always @(posedge clk) begin
    if (sink_stall_left > 1) begin
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
      res_ch.ready    <= 1'b0;
      sink_stall_left <= $urandom_range(1, 17);
    end else begin
      res_ch.ready    <= 1'b1;
      sink_stall_left <= 0;
    end
  end

  // Compare each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        head_verdict = pending_verdicts.pop_front();
        check_field("status", 16'(res_ch.status), 16'(head_verdict.status));
        check_field("packet_type", 16'(res_ch.packet_type), 16'(head_verdict.ptype));
        check_field("node_id", res_ch.node_id, head_verdict.node);
        check_field("sequence_number", res_ch.sequence_number, head_verdict.seq);
        check_field("header_payload_length", res_ch.header_payload_length,
                    head_verdict.hlen);
        check_field("command_id", 16'(res_ch.command_id), 16'(head_verdict.cmd));
        check_field("command_payload_length", res_ch.command_payload_length,
                    head_verdict.cpl);
      end
    end
  end

  initial begin
    logic [7:0]    frame_q[$];
    verdict_word_t tv;
    probe_row_t    r;
    cfg_t          next_cfg;
    int            prev_phase;
    int            phase_bytes;
    int            n_sent;
    int            guard;

    // Hold every input at a known value from time zero.
    rst              = 1'b1;
    pkt_ch.valid     = 1'b0;
    pkt_ch.data_byte = '0;
    pkt_ch.last_byte = 1'b0;
    res_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;

    // Reset settings of the register file, mirrored in the predictor.
    cfg.protocol_version    = 8'd1;
    cfg.command_type_code   = 8'd1;
    cfg.response_type_code  = 8'd2;
    cfg.telemetry_type_code = 8'd3;
    cfg.max_payload_length  = 16'd256;
    cfg.max_packet_length   = 16'd266;
    cfg.command_valid_mask  = '0;
    cfg.parse_command_mode  = 1'b1;
    frame_clear();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed packets: every status code, field extremes, short packets.
    prev_phase = 0;
    foreach (probe_rows[i]) begin
      r = probe_rows[i];
      if (r.phase != prev_phase) begin
        drain_results();
        if (r.phase == 1) begin
          cfg_write(REG_COMMAND_VALID_MASK, '1);
          cfg_write(REG_MAX_PAYLOAD_LENGTH, 64'hFFFF);
          cfg_write(REG_MAX_PACKET_LENGTH, 64'hFFFF);
        end else begin
          cfg_write(REG_PARSE_COMMAND_MODE, 64'd0);
          cfg_write(REG_COMMAND_VALID_MASK, 64'd0);
        end
        prev_phase = r.phase;
      end
      build_frame(frame_q, r.ver, r.ptype, r.node, r.seq, r.hlen, r.plen, r.cmd,
                  r.good_crc);
      // Truncate to make a short packet; missing fields read as zero.
      if (r.cut > 0)
        while (frame_q.size() > r.cut) frame_q.pop_back();
      tv = '{status: r.st, ptype: r.ptype, node: r.node, seq: r.seq, hlen: r.hlen,
             cmd: r.cmd, cpl: r.cpl};
      send_frame(frame_q, r.typed, tv);
    end

    // Random phases: lowest settings, highest settings, then random ones.
    // The last phase runs without idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      if (ph == 0) begin
        next_cfg = '0;
        next_cfg.max_packet_length = 16'(MIN_PACKET_LEN);
      end else if (ph == 1) begin
        next_cfg.protocol_version    = 8'hFF;
        next_cfg.command_type_code   = 8'hFF;
        next_cfg.response_type_code  = 8'hFE;
        next_cfg.telemetry_type_code = 8'hFD;
        next_cfg.max_payload_length  = 16'hFFFF;
        next_cfg.max_packet_length   = 16'hFFFF;
        next_cfg.command_valid_mask  = '1;
        next_cfg.parse_command_mode  = 1'b1;
      end else begin
        next_cfg.protocol_version    = 8'($urandom);
        next_cfg.command_type_code   = 8'($urandom);
        next_cfg.response_type_code  = 8'($urandom);
        next_cfg.telemetry_type_code = 8'($urandom);
        next_cfg.max_payload_length  = 16'($urandom_range(0, 40));
        next_cfg.max_packet_length   = 16'($urandom_range(10, 70));
        next_cfg.command_valid_mask  = {$urandom, $urandom};
        next_cfg.parse_command_mode  = 1'($urandom_range(0, 1));
      end
      cfg_write(REG_PROTOCOL_VERSION, 64'(next_cfg.protocol_version));
      cfg_write(REG_COMMAND_TYPE_CODE, 64'(next_cfg.command_type_code));
      cfg_write(REG_RESPONSE_TYPE_CODE, 64'(next_cfg.response_type_code));
      cfg_write(REG_TELEMETRY_TYPE_CODE, 64'(next_cfg.telemetry_type_code));
      cfg_write(REG_MAX_PAYLOAD_LENGTH, 64'(next_cfg.max_payload_length));
      cfg_write(REG_MAX_PACKET_LENGTH, 64'(next_cfg.max_packet_length));
      cfg_write(REG_COMMAND_VALID_MASK, next_cfg.command_valid_mask);
      cfg_write(REG_PARSE_COMMAND_MODE, 64'(next_cfg.parse_command_mode));

      src_idle_en  = (ph != 5) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (ph != 5) && ($urandom_range(0, 3) != 0);
      phase_bytes = 0;
      while (phase_bytes < 40) begin
        send_random_frame(n_sent);
        phase_bytes += n_sent;
        // Now and then hold the sender until every verdict is back.
        if (ph != 5 && $urandom_range(0, 15) == 0)
          drain_results();
      end
    end

    // Wait out the outstanding verdicts, then the pipeline depth.
    pkt_ch.valid <= 1'b0;
    guard = 0;
    while (pending_verdicts.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
